// File: src/gbm_pkg.sv
// shared types and constants of the group-by min/max/sum/count engine
// used by gbm_table, gbm_update and group_by_min_max_sum_count
package gbm_pkg;

    localparam int YEAR_SLOTS = 64;
    localparam int SLOT_W     = $clog2(YEAR_SLOTS);
    localparam int KEY_W      = 16;
    localparam int SCORE_W    = 32;
    localparam int SUM_W      = 64;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = KEY_W + SCORE_W;
    localparam int OUT_DATA_W = KEY_W + 2 * SCORE_W + SUM_W + CNT_W;

    localparam logic [KEY_W-1:0] BASE_YEAR_RESET = 16'd2000;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_ENTRY = 2'd0;
    localparam status_t STATUS_RANGE = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] min_score;
        logic signed [SCORE_W-1:0] max_score;
        logic signed [SUM_W-1:0]   sum_score;
        logic [CNT_W-1:0]          record_count;
    } entry_t;

endpackage

// File: src/gbm_table.sv
// per-slot aggregate memory: one write port, one read port, registered read
// depends on gbm_pkg
module gbm_table
    import gbm_pkg::*;
(
    input  logic   clk,
    input  logic   wr_en,
    input  slot_t  wr_addr,
    input  entry_t wr_data,
    input  logic   rd_en,
    input  slot_t  rd_addr,
    output entry_t rd_data
);

    entry_t mem_reg [YEAR_SLOTS];
    entry_t rd_data_reg;

    // read during write to the same slot returns the old entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/gbm_update.sv
// folds one score into a slot entry: min, max, 64-bit sum, saturating count
// depends on gbm_pkg
module gbm_update
    import gbm_pkg::*;
(
    input  entry_t                    cur,
    input  logic                      first,
    input  logic signed [SCORE_W-1:0] score,
    output entry_t                    upd
);

    logic signed [SUM_W-1:0] score_ext;

    assign score_ext = SUM_W'(score);

    always_comb
    begin
        if (first)
        begin
            upd.min_score    = score;
            upd.max_score    = score;
            upd.sum_score    = score_ext;
            upd.record_count = CNT_W'(1);
        end
        else
        begin
            upd.min_score    = (score < cur.min_score) ? score : cur.min_score;
            upd.max_score    = (cur.max_score < score) ? score : cur.max_score;
            upd.sum_score    = cur.sum_score + score_ext;
            upd.record_count = (cur.record_count == '1) ? cur.record_count
                                                        : cur.record_count + CNT_W'(1);
        end
    end

endmodule

// File: src/group_by_min_max_sum_count.sv
// group-by aggregation engine, top level; uses gbm_pkg, gbm_table, gbm_update
// records: one transfer per cycle unless stalled; slot read at accept, written back the cycle after
// out-of-range record: its result enters the output register once the output is free
// dump: scans slots 0 up to the highest occupied slot, one slot per cycle unless the output stalls, through the
//   table read port; input is held off until the last report is registered
// reset: base year 2000, slot valid bits cleared at once, no clearing pass
module group_by_min_max_sum_count
    import gbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [KEY_W-1:0]      cfg_data,    // base_year
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // year_key, score_value
    input  logic [0:0]            s_tuser,     // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // out_year, min, max, sum, record_count
    output logic                  m_tlast,
    output logic [1:0]            m_tuser      // status
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t                    state_reg;
    logic [KEY_W-1:0]          base_year_reg;
    logic [YEAR_SLOTS-1:0]     slot_valid_reg;
    logic                      any_reg;
    slot_t                     hi_slot_reg;

    logic                      s1_valid_reg;
    logic                      s1_in_range_reg;
    slot_t                     s1_idx_reg;
    logic [KEY_W-1:0]          s1_year_reg;
    logic signed [SCORE_W-1:0] s1_score_reg;

    logic                      wb_valid_reg;
    slot_t                     wb_idx_reg;
    entry_t                    wb_data_reg;

    logic                      d1_valid_reg;
    slot_t                     d1_slot_reg;
    logic                      d1_last_reg;
    slot_t                     slot_reg;

    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic                      m_tlast_reg;
    status_t                   m_tuser_reg;

    logic                      in_acc;
    logic                      in_op;
    logic [KEY_W-1:0]          in_year;
    logic signed [SCORE_W-1:0] in_score;
    logic [KEY_W-1:0]          idx_full;
    logic                      in_range;
    logic                      out_free;
    logic                      s1_done;
    logic                      wr_en;
    logic                      rd_en;
    slot_t                     rd_addr;
    entry_t                    rd_data;
    entry_t                    cur_entry;
    entry_t                    upd_entry;
    logic                      first;
    logic                      dump_adv;
    logic                      err_load;
    logic                      d1_load;
    logic                      empty_load;

    assign in_acc   = s_tvalid && s_tready;
    assign in_op    = s_tuser[0];
    assign in_year  = s_tdata[KEY_W-1:0];
    assign in_score = s_tdata[IN_DATA_W-1:KEY_W];
    assign idx_full = in_year - base_year_reg;
    assign in_range = idx_full < KEY_W'(YEAR_SLOTS);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s1_done   = !s1_valid_reg || s1_in_range_reg || out_free;
    assign s_tready  = (state_reg == ST_IDLE) && !d1_valid_reg && s1_done;
    assign cfg_ready = 1'b1;

    assign wr_en = s1_valid_reg && s1_in_range_reg;
    // the slot written last cycle is not yet visible in this cycle's read data
    assign cur_entry = (wb_valid_reg && (wb_idx_reg == s1_idx_reg)) ? wb_data_reg : rd_data;
    assign first     = !slot_valid_reg[s1_idx_reg];

    assign dump_adv   = (state_reg == ST_DUMP) && any_reg && (!d1_valid_reg || out_free);
    assign err_load   = s1_valid_reg && !s1_in_range_reg && out_free;
    assign d1_load    = d1_valid_reg && out_free;
    assign empty_load = (state_reg == ST_DUMP) && !any_reg && out_free;

    assign rd_en   = (in_acc && (in_op == OP_RECORD) && in_range)
                  || (dump_adv && slot_valid_reg[slot_reg]);
    assign rd_addr = (state_reg == ST_DUMP) ? slot_reg : idx_full[SLOT_W-1:0];

    gbm_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (upd_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbm_update u_update (
        .cur   (cur_entry),
        .first (first),
        .score (s1_score_reg),
        .upd   (upd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_year_reg  <= BASE_YEAR_RESET;
            slot_valid_reg <= '0;
            any_reg        <= 1'b0;
            hi_slot_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            wb_valid_reg   <= 1'b0;
            d1_valid_reg   <= 1'b0;
            slot_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_year_reg <= cfg_data;
            end

            if (in_acc && (in_op == OP_RECORD))
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end

            wb_valid_reg <= wr_en;
            if (wr_en)
            begin
                slot_valid_reg[s1_idx_reg] <= 1'b1;
                any_reg                    <= 1'b1;
                if (!any_reg || (s1_idx_reg > hi_slot_reg))
                begin
                    hi_slot_reg <= s1_idx_reg;
                end
            end

            if (dump_adv)
            begin
                d1_valid_reg <= slot_valid_reg[slot_reg];
            end
            else if (d1_load)
            begin
                d1_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (in_op == OP_DUMP))
                    begin
                        state_reg <= ST_DUMP;
                        slot_reg  <= '0;
                    end
                end
                ST_DUMP:
                begin
                    if (empty_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (dump_adv)
                    begin
                        if (slot_reg == hi_slot_reg)
                        begin
                            // last occupied slot issued: the table is empty from here
                            state_reg      <= ST_IDLE;
                            slot_reg       <= '0;
                            slot_valid_reg <= '0;
                            any_reg        <= 1'b0;
                            hi_slot_reg    <= '0;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + SLOT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (err_load || d1_load || empty_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && (in_op == OP_RECORD))
        begin
            s1_in_range_reg <= in_range;
            s1_idx_reg      <= idx_full[SLOT_W-1:0];
            s1_year_reg     <= in_year;
            s1_score_reg    <= in_score;
        end

        wb_idx_reg  <= s1_idx_reg;
        wb_data_reg <= upd_entry;

        if (dump_adv)
        begin
            d1_slot_reg <= slot_reg;
            d1_last_reg <= (slot_reg == hi_slot_reg);
        end

        priority if (err_load)
        begin
            m_tdata_reg <= {{(OUT_DATA_W - KEY_W){1'b0}}, s1_year_reg};
            m_tlast_reg <= 1'b0;
            m_tuser_reg <= STATUS_RANGE;
        end
        else if (d1_load)
        begin
            m_tdata_reg <= {rd_data.record_count, rd_data.sum_score, rd_data.max_score,
                            rd_data.min_score, base_year_reg + KEY_W'(d1_slot_reg)};
            m_tlast_reg <= d1_last_reg;
            m_tuser_reg <= STATUS_ENTRY;
        end
        else if (empty_load)
        begin
            m_tdata_reg <= '0;
            m_tlast_reg <= 1'b1;
            m_tuser_reg <= STATUS_EMPTY;
        end
        else
        begin
            m_tdata_reg <= m_tdata_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // a written slot is marked occupied on the next cycle
    a_write_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> slot_valid_reg[$past(s1_idx_reg)])
        else $error("written slot not marked occupied");

    // the dump scan never overlaps a record still in flight
    a_dump_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> !s1_valid_reg)
        else $error("record in flight during dump");

    // a table flagged empty has no slot valid bits set
    a_any_matches: assert property (@(posedge clk) disable iff (!rst_n)
        !any_reg |-> (slot_valid_reg == '0))
        else $error("occupied slot while table flagged empty");

endmodule

// File: tb/tb_group_by_min_max_sum_count.sv
// self-checking testbench for the group-by min/max/sum/count engine
// the scoreboard class predicts the reports; depends on gbm_pkg and group_by_min_max_sum_count
module tb_group_by_min_max_sum_count;
    import gbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SHOWN = 10;

    class gbm_scoreboard;
        typedef struct {
            logic [KEY_W-1:0]          year;
            logic signed [SCORE_W-1:0] min_score;
            logic signed [SCORE_W-1:0] max_score;
            logic signed [SUM_W-1:0]   sum_score;
            logic [CNT_W-1:0]          record_count;
            logic                      last;
            status_t                   status;
        } group_report_t;

        logic [KEY_W-1:0]          base_year;
        logic signed [SCORE_W-1:0] min_tbl [YEAR_SLOTS];
        logic signed [SCORE_W-1:0] max_tbl [YEAR_SLOTS];
        logic signed [SUM_W-1:0]   sum_tbl [YEAR_SLOTS];
        logic [CNT_W-1:0]          cnt_tbl [YEAR_SLOTS];
        group_report_t             expected_reports [$];
        int mismatches;
        int reports_checked;
        int records_taken;
        int dumps_taken;
        int range_drops;

        function new();
            base_year = BASE_YEAR_RESET;
            foreach (cnt_tbl[i])
                cnt_tbl[i] = '0;
            mismatches = 0;
            reports_checked = 0;
            records_taken = 0;
            dumps_taken = 0;
            range_drops = 0;
        endfunction

        function void set_base(logic [KEY_W-1:0] value);
            base_year = value;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void add_report(group_report_t rep);
            expected_reports.insert(expected_reports.size(), rep);
        endfunction

        // fold one accepted transfer into the tables and queue the reports it causes
        function void note_input(logic op, logic [KEY_W-1:0] year,
                                 logic signed [SCORE_W-1:0] score);
            logic [KEY_W-1:0] idx;
            slot_t slot;
            group_report_t rep;
            int top;
            if (op == OP_RECORD)
            begin
                records_taken++;
                idx = year - base_year;
                if (idx >= YEAR_SLOTS)
                begin
                    range_drops++;
                    rep = '{year, '0, '0, '0, '0, 1'b0, STATUS_RANGE};
                    add_report(rep);
                    return;
                end
                slot = idx[SLOT_W-1:0];
                if (cnt_tbl[slot] == '0)
                begin
                    min_tbl[slot] = score;
                    max_tbl[slot] = score;
                    sum_tbl[slot] = '0;
                end
                else
                begin
                    if (score < min_tbl[slot])
                        min_tbl[slot] = score;
                    if (score > max_tbl[slot])
                        max_tbl[slot] = score;
                end
                sum_tbl[slot] = sum_tbl[slot] + {{(SUM_W-SCORE_W){score[SCORE_W-1]}}, score};
                if (cnt_tbl[slot] != '1)
                    cnt_tbl[slot] = cnt_tbl[slot] + 32'd1;
            end
            else
            begin
                dumps_taken++;
                top = -1;
                for (int s = 0; s < YEAR_SLOTS; s++)
                    if (cnt_tbl[s] != '0)
                        top = s;
                if (top < 0)
                begin
                    rep = '{'0, '0, '0, '0, '0, 1'b1, STATUS_EMPTY};
                    add_report(rep);
                    return;
                end
                for (int s = 0; s < YEAR_SLOTS; s++)
                begin
                    if (cnt_tbl[s] != '0)
                    begin
                        rep = '{base_year + KEY_W'(s), min_tbl[s], max_tbl[s], sum_tbl[s],
                                cnt_tbl[s], (s == top), STATUS_ENTRY};
                        add_report(rep);
                    end
                    cnt_tbl[s] = '0;
                end
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last, status_t status);
            group_report_t got;
            group_report_t exp;
            got.year         = data[KEY_W-1:0];
            got.min_score    = data[KEY_W +: SCORE_W];
            got.max_score    = data[KEY_W+SCORE_W +: SCORE_W];
            got.sum_score    = data[KEY_W+2*SCORE_W +: SUM_W];
            got.record_count = data[KEY_W+2*SCORE_W+SUM_W +: CNT_W];
            got.last         = last;
            got.status       = status;
            reports_checked++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected report: year=%0d status=%0d last=%0d",
                             got.year, got.status, got.last);
                return;
            end
            exp = expected_reports.pop_front();
            if (got.year != exp.year || got.min_score != exp.min_score
                || got.max_score != exp.max_score || got.sum_score != exp.sum_score
                || got.record_count != exp.record_count || got.last != exp.last
                || got.status != exp.status)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("report mismatch at %0t", $realtime);
                    $display("  expected year=%0d min=%0d max=%0d sum=%0d count=%0d last=%0d st=%0d",
                             exp.year, exp.min_score, exp.max_score, exp.sum_score,
                             exp.record_count, exp.last, exp.status);
                    $display("  actual   year=%0d min=%0d max=%0d sum=%0d count=%0d last=%0d st=%0d",
                             got.year, got.min_score, got.max_score, got.sum_score,
                             got.record_count, got.last, got.status);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [KEY_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // year_key, score_value
    logic [0:0]            s_tuser;    // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;    // out_year, min, max, sum, record_count
    logic                  m_tlast;
    logic [1:0]            m_tuser;    // status

    gbm_scoreboard    sb;
    logic [KEY_W-1:0] cur_base;
    bit               idle_on;
    int               stall_left = 0;
    int               cycles = 0;

    group_by_min_max_sum_count uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding", cycles, sb.pending());
            $display("tb_group_by_min_max_sum_count: FAIL");
            $finish;
        end
    end

    // sink side: random stall bursts while idling is enabled
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_base(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser[0], s_tdata[KEY_W-1:0], s_tdata[KEY_W +: SCORE_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    task automatic push_item(input logic op, input logic [KEY_W-1:0] year,
                             input logic [SCORE_W-1:0] score);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {score, year};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // base year may only change once the engine has drained
    task automatic write_base(input logic [KEY_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_base = value;
    endtask

    initial
    begin
        logic [KEY_W-1:0]   phase_base [4];
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   year;
        int                 pick;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        idle_on = 1'b1;
        cur_base = BASE_YEAR_RESET;
        sb = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, extreme scores in one slot, both ends of the table, out-of-range keys
        push_item(OP_DUMP, 16'd0, 32'd0);
        push_item(OP_RECORD, 16'd2000, 32'h7FFF_FFFF);
        push_item(OP_RECORD, 16'd2000, 32'h8000_0000);
        push_item(OP_RECORD, 16'd2000, 32'd0);
        push_item(OP_RECORD, 16'd2063, 32'hFFFF_FFFF);
        push_item(OP_RECORD, 16'd2064, 32'd5);
        push_item(OP_RECORD, 16'd1999, 32'd5);
        push_item(OP_RECORD, 16'hFFFF, 32'hFFFF_FFFF);
        push_item(OP_RECORD, 16'd0, 32'd1);
        push_item(OP_RECORD, 16'd2063, 32'h8000_0000);
        push_item(OP_RECORD, 16'd2031, 32'd12345);
        push_item(OP_RECORD, 16'd2031, -32'sd12345);
        push_item(OP_RECORD, 16'd2031, 32'h5555_5555);
        push_item(OP_DUMP, 16'hFFFF, 32'hFFFF_FFFF);
        push_item(OP_DUMP, 16'd0, 32'd0);

        write_base(16'd65500);
        push_item(OP_RECORD, 16'hFFFF, 32'd7);
        push_item(OP_RECORD, 16'd65500, 32'hAAAA_AAAA);
        push_item(OP_RECORD, 16'd65499, 32'd1);
        push_item(OP_DUMP, 16'd0, 32'd0);

        // reported year wraps past the top of the key range
        write_base(16'hFFFF);
        push_item(OP_RECORD, 16'd0, 32'd3);
        push_item(OP_RECORD, 16'd62, -32'sd3);
        push_item(OP_RECORD, 16'hFFFF, 32'h0000_FFFF);
        push_item(OP_DUMP, 16'd0, 32'd0);

        write_base(16'd0);
        push_item(OP_RECORD, 16'd63, 32'h1234_5678);
        push_item(OP_RECORD, 16'd64, 32'd9);
        push_item(OP_DUMP, 16'd0, 32'd0);

        phase_base[0] = 16'($urandom);
        phase_base[1] = 16'hFFE0;
        phase_base[2] = BASE_YEAR_RESET;
        phase_base[3] = 16'($urandom);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_base(phase_base[ph]);
            if (ph == 3)
                idle_on = 1'b0;
            for (int n = 0; n < 38; n++)
            begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 7))
                    0: score = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    1, 2: score = 32'($urandom_range(0, 200)) - 32'd100;
                    default: score = $urandom;
                endcase
                if (pick < 7)
                    push_item(OP_DUMP, 16'($urandom), $urandom);
                else if (pick < 15)
                    push_item(OP_RECORD, 16'($urandom), score);
                else
                begin
                    // a few hot slots give back-to-back updates of the same entry
                    if (pick < 45)
                        year = cur_base + 16'($urandom_range(0, 3));
                    else
                        year = cur_base + 16'($urandom_range(0, YEAR_SLOTS - 1));
                    push_item(OP_RECORD, year, score);
                end
            end
            push_item(OP_DUMP, 16'd0, 32'd0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        $display("covered %0d records (%0d out of range) and %0d dumps across eight base-year settings",
                 sb.records_taken, sb.range_drops, sb.dumps_taken);
        $display("checked %0d reports, %0d mismatches", sb.reports_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_group_by_min_max_sum_count: PASS");
        else
            $display("tb_group_by_min_max_sum_count: FAIL");
        $finish;
    end

endmodule
